>>> rtl/erq_pkg.sv
// Shared types, codes and helpers for the event registration queue.
package erq_pkg;

   localparam int SLOTS_DEF         = 16;
   localparam int BACKLOG_DEPTH_DEF = 4;

   localparam logic [2:0] REQ_ADD     = 3'd0;
   localparam logic [2:0] REQ_TRIGGER = 3'd1;
   localparam logic [2:0] REQ_DELETE  = 3'd2;
   localparam logic [2:0] REQ_POLL    = 3'd3;
   localparam logic [2:0] REQ_CLOSE   = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_CLOSED   = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NONE     = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;

   localparam logic [1:0] KIND_LEVEL   = 2'd0;
   localparam logic [1:0] KIND_EDGE    = 2'd1;
   localparam logic [1:0] KIND_ONESHOT = 2'd2;
   localparam logic [1:0] KIND_QUEUED  = 2'd3;

   localparam logic [5:0] FL_ADD     = 6'h01;
   localparam logic [5:0] FL_ONESHOT = 6'h10;
   localparam logic [5:0] FL_CLEAR   = 6'h20;

   localparam logic [6:0] POLL_MAX = 7'd64;

   typedef struct packed {
      logic        valid;
      logic [31:0] ident;
      logic        filter;
      logic [1:0]  kind;
      logic        ready;
      logic [63:0] data;
      logic [63:0] udata;
      logic [63:0] deadline;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic shift;
      logic load;
      logic update;
      logic trigger;
      logic expire;
      logic pop;
   } cell_cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] ident;
      logic        filter;
      logic [5:0]  flags;
      logic [63:0] data;
      logic [63:0] udata;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] ident;
      logic        filter;
      logic [1:0]  entry_kind;
      logic [63:0] word;
      logic [63:0] delay;
      logic [6:0]  num;
      logic [63:0] now;
   } request_type;

   function automatic logic [5:0] kind_flags(input logic [1:0] k);
      case (k)
         KIND_LEVEL:   kind_flags = FL_ADD;
         KIND_ONESHOT: kind_flags = FL_ADD | FL_ONESHOT;
         default:      kind_flags = FL_ADD | FL_CLEAR;
      endcase
   endfunction

endpackage

>>> rtl/event_registration_queue.sv
// Top level of the event registration queue: request control and cell chain.
//
// Requests arrive on the req_ channel (req_valid / req_stall) and results
// leave on the rsp_ channel (rsp_valid / rsp_stall). A transaction is taken
// when valid is high and stall is low. Registrations live in a chain of
// SLOTS cells kept in registration order; a delete or a one-shot report
// shifts the later cells down by one.
// Add, trigger, delete and close give one result: the request is registered,
// then decided and written to the output register once that register is
// free, after which the next request can be taken. A poll first expires
// timers, then walks the cells in order, passing idle cells and reporting
// ready events, and ends with its closing result, after at most max_count
// events, clamped to 1 to 64. Requests with codes 5 to 7
// give no result. A new request is taken once the previous one has finished;
// the output register lets it be taken while a result still waits.
// A stalled result holds; the walk of a poll pauses while the output
// register is full and stalled. Reset empties the table, reopens a closed
// queue and drops any pending result.
module event_registration_queue import erq_pkg::*; #(
   parameter int SLOTS         = SLOTS_DEF,
   parameter int BACKLOG_DEPTH = BACKLOG_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_ident,
   input  logic        req_filter_kind,
   input  logic [1:0]  req_entry_kind,
   input  logic [63:0] req_user_word,
   input  logic [63:0] req_delay_ns,
   input  logic [6:0]  req_max_count,
   input  logic [63:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_ev_ident,
   output logic        rsp_ev_filter,
   output logic [5:0]  rsp_ev_flags,
   output logic [63:0] rsp_ev_data,
   output logic [63:0] rsp_ev_udata,
   output logic        rsp_last
);

   localparam int IDXW = $clog2(SLOTS);
   localparam int CNTS = $clog2(SLOTS + 1);
   localparam int CNTW = $clog2(BACKLOG_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK} state_type;

   state_type   state_ff, state_in;
   request_type req_ff, req_in;
   rsp_type     rsp_ff, rsp_in, hold_ff, hold_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        hold_valid_ff, hold_valid_in;
   logic        closed_ff, closed_in;
   logic [CNTS-1:0] live_ff, live_in;
   logic [CNTS-1:0] p_ff, p_in;
   logic [6:0]  ret_ff, ret_in;
   logic [6:0]  num_ff, num_in;

   entry_type                      entry_w   [SLOTS];
   logic [BACKLOG_DEPTH-1:0][63:0] backlog_w [SLOTS];
   logic [CNTW-1:0]                count_w   [SLOTS];
   cell_cmd_type                   cmd_w     [SLOTS];
   logic [SLOTS-1:0]               match;
   logic [SLOTS-1:0]               valid_vec;
   logic [IDXW-1:0]                match_idx, rm_idx;
   logic                           match_any;
   logic close_go, rm_go, load_go, update_go, trig_go, expire_go, pop_go;
   logic        out_free;
   logic [64:0] dl_sum;
   logic [63:0] dl;
   entry_type   new_entry, sel, msel;
   logic [CNTW-1:0] sel_cnt, msel_cnt;
   logic [IDXW-1:0] p_idx, live_idx;
   rsp_type     plain, event_r;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign p_idx    = p_ff[IDXW-1:0];
   assign live_idx = live_ff[IDXW-1:0];

   always_comb begin
      match_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (match[i]) match_idx = match_idx | IDXW'(i);
      end
   end
   assign match_any = |match;
   assign msel      = entry_w[match_idx];
   assign msel_cnt  = count_w[match_idx];
   assign sel       = entry_w[p_idx];
   assign sel_cnt   = count_w[p_idx];

   always_comb begin
      dl_sum = {1'b0, req_ff.now} + {1'b0, req_ff.delay};
      dl     = dl_sum[64] ? '1 : dl_sum[63:0];
      if (dl == '0) dl = 64'd1;
      if (req_ff.entry_kind != KIND_ONESHOT) dl = '0;
   end

   always_comb begin
      new_entry          = '0;
      new_entry.valid    = 1'b1;
      new_entry.ident    = req_ff.ident;
      new_entry.filter   = req_ff.filter;
      new_entry.kind     = req_ff.entry_kind;
      new_entry.udata    = req_ff.word;
      new_entry.deadline = dl;
   end

   always_comb begin
      event_r        = '0;
      event_r.status = ST_OK;
      event_r.ident  = sel.ident;
      event_r.filter = sel.filter;
      event_r.flags  = kind_flags(sel.kind);
      event_r.data   = sel.data;
      event_r.udata  = sel.udata;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      closed_in     = closed_ff;
      live_in       = live_ff;
      p_in          = p_ff;
      ret_in        = ret_ff;
      num_in        = num_ff;
      close_go      = 1'b0;
      rm_go         = 1'b0;
      rm_idx        = match_idx;
      load_go       = 1'b0;
      update_go     = 1'b0;
      trig_go       = 1'b0;
      expire_go     = 1'b0;
      pop_go        = 1'b0;
      plain         = '0;
      plain.last    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = '{kind: req_type, ident: req_ident, filter: req_filter_kind,
                          entry_kind: req_entry_kind, word: req_user_word,
                          delay: req_delay_ns, num: req_max_count, now: req_now_time};
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               plain.status = ST_OK;
               if (req_ff.kind == REQ_CLOSE) begin
                  if (closed_ff) begin
                     plain.status = ST_CLOSED;
                  end else begin
                     close_go  = 1'b1;
                     closed_in = 1'b1;
                     live_in   = '0;
                  end
               end else if (req_ff.kind > REQ_CLOSE) begin
                  rsp_valid_in = 1'b0;
               end else if (closed_ff) begin
                  plain.status = ST_CLOSED;
               end else if (req_ff.kind == REQ_POLL) begin
                  rsp_valid_in = 1'b0;
                  expire_go    = 1'b1;
                  p_in         = '0;
                  ret_in       = '0;
                  num_in       = (req_ff.num == '0) ? 7'd1 :
                                 (req_ff.num > POLL_MAX) ? POLL_MAX : req_ff.num;
                  state_in     = S_WALK;
               end else if (req_ff.kind == REQ_ADD) begin
                  if (match_any) begin
                     update_go = 1'b1;
                  end else if (live_ff == CNTS'(SLOTS)) begin
                     plain.status = ST_FULL;
                  end else begin
                     load_go = 1'b1;
                     live_in = live_ff + 1'b1;
                  end
               end else if (!match_any) begin
                  plain.status = ST_NOTFOUND;
               end else if (req_ff.kind == REQ_DELETE) begin
                  rm_go   = 1'b1;
                  live_in = live_ff - 1'b1;
               end else begin
                  trig_go = 1'b1;
                  if (msel.kind == KIND_QUEUED && msel.ready &&
                      msel_cnt == CNTW'(BACKLOG_DEPTH)) begin
                     plain.status = ST_OVERFLOW;
                  end
               end
               rsp_in = plain;
            end
         end
         S_WALK: begin
            if (out_free) begin
               if (p_ff >= live_ff || ret_ff >= num_ff) begin
                  rsp_valid_in  = 1'b1;
                  plain.status  = ST_NONE;
                  rsp_in        = plain;
                  if (hold_valid_ff) begin
                     rsp_in      = hold_ff;
                     rsp_in.last = 1'b1;
                  end
                  hold_valid_in = 1'b0;
                  state_in      = S_IDLE;
               end else if (!sel.ready) begin
                  p_in = p_ff + 1'b1;
               end else begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = hold_ff;
                  end
                  hold_in       = event_r;
                  hold_valid_in = 1'b1;
                  ret_in        = ret_ff + 1'b1;
                  if (sel.kind == KIND_ONESHOT) begin
                     rm_go   = 1'b1;
                     rm_idx  = p_idx;
                     live_in = live_ff - 1'b1;
                  end else begin
                     pop_go = 1'b1;
                     if (!(sel.kind != KIND_LEVEL && sel_cnt != '0)) p_in = p_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      entry_type                      nb_e;
      logic [BACKLOG_DEPTH-1:0][63:0] nb_b;
      logic [CNTW-1:0]                nb_c;

      if (i < SLOTS - 1) begin : g_link
         assign nb_e = entry_w[i+1];
         assign nb_b = backlog_w[i+1];
         assign nb_c = count_w[i+1];
      end else begin : g_end
         assign nb_e = '0;
         assign nb_b = '0;
         assign nb_c = '0;
      end

      assign match[i] = entry_w[i].valid && entry_w[i].ident == req_ff.ident &&
                        entry_w[i].filter == req_ff.filter;
      assign valid_vec[i] = entry_w[i].valid;

      assign cmd_w[i] = '{clear:   close_go,
                          shift:   rm_go && IDXW'(i) >= rm_idx,
                          load:    load_go && IDXW'(i) == live_idx,
                          update:  update_go && match[i],
                          trigger: trig_go && match[i],
                          expire:  expire_go,
                          pop:     pop_go && IDXW'(i) == p_idx};

      erq_cell #(.BACKLOG_DEPTH(BACKLOG_DEPTH)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd_w[i]),
         .new_entry  (new_entry),
         .word       (req_ff.word),
         .deadline   (dl),
         .now        (req_ff.now),
         .nb_entry   (nb_e),
         .nb_backlog (nb_b),
         .nb_count   (nb_c),
         .entry      (entry_w[i]),
         .backlog    (backlog_w[i]),
         .count      (count_w[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         closed_ff     <= 1'b0;
         live_ff       <= '0;
         p_ff          <= '0;
         ret_ff        <= '0;
         num_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
         closed_ff     <= closed_in;
         live_ff       <= live_in;
         p_ff          <= p_in;
         ret_ff        <= ret_in;
         num_ff        <= num_in;
      end
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign req_stall     = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_ff.status;
   assign rsp_ev_ident  = rsp_ff.ident;
   assign rsp_ev_filter = rsp_ff.filter;
   assign rsp_ev_flags  = rsp_ff.flags;
   assign rsp_ev_data   = rsp_ff.data;
   assign rsp_ev_udata  = rsp_ff.udata;
   assign rsp_last      = rsp_ff.last;

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNTS'(SLOTS)) else $error("live count above slot count");

   a_compact: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(live_ff)) else $error("valid cells differ from live count");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !hold_valid_ff) else $error("held event left after poll");

   a_ret_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> ret_ff <= num_ff) else $error("poll reported too many events");

endmodule

>>> rtl/erq_cell.sv
// One registration cell: entry, backlog and shift link to the next cell.
module erq_cell import erq_pkg::*; #(
   parameter int BACKLOG_DEPTH = BACKLOG_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cell_cmd_type                         cmd,
   input  entry_type                            new_entry,
   input  logic [63:0]                          word,
   input  logic [63:0]                          deadline,
   input  logic [63:0]                          now,
   input  entry_type                            nb_entry,
   input  logic [BACKLOG_DEPTH-1:0][63:0]       nb_backlog,
   input  logic [$clog2(BACKLOG_DEPTH+1)-1:0]   nb_count,
   output entry_type                            entry,
   output logic [BACKLOG_DEPTH-1:0][63:0]       backlog,
   output logic [$clog2(BACKLOG_DEPTH+1)-1:0]   count
);

   localparam int CNTW = $clog2(BACKLOG_DEPTH + 1);

   entry_type                      entry_ff, entry_in;
   logic [BACKLOG_DEPTH-1:0][63:0] backlog_ff, backlog_in;
   logic [CNTW-1:0]                count_ff, count_in;

   always_comb begin
      entry_in   = entry_ff;
      backlog_in = backlog_ff;
      count_in   = count_ff;
      if (cmd.clear) begin
         entry_in.valid = 1'b0;
         entry_in.ready = 1'b0;
         count_in       = '0;
      end else if (cmd.shift) begin
         entry_in   = nb_entry;
         backlog_in = nb_backlog;
         count_in   = nb_count;
      end else if (cmd.load) begin
         entry_in = new_entry;
         count_in = '0;
      end else if (cmd.update) begin
         entry_in.deadline = deadline;
         entry_in.udata    = word;
      end else if (cmd.trigger) begin
         case (entry_ff.kind)
            KIND_LEVEL, KIND_EDGE: begin
               entry_in.ready = 1'b1;
               entry_in.data  = word;
               entry_in.udata = word;
            end
            KIND_ONESHOT: entry_in.ready = 1'b1;
            default: begin
               if (!entry_ff.ready) begin
                  entry_in.ready = 1'b1;
                  entry_in.data  = word;
               end else if (count_ff < CNTW'(BACKLOG_DEPTH)) begin
                  for (int j = 0; j < BACKLOG_DEPTH; j++) begin
                     if (count_ff == CNTW'(j)) backlog_in[j] = word;
                  end
                  count_in = count_ff + 1'b1;
               end
            end
         endcase
      end else if (cmd.expire) begin
         if (entry_ff.valid && !entry_ff.ready && entry_ff.deadline != '0 &&
             entry_ff.deadline <= now) begin
            entry_in.ready = 1'b1;
         end
      end else if (cmd.pop) begin
         if (entry_ff.kind != KIND_LEVEL) begin
            entry_in.ready = 1'b0;
            entry_in.data  = '0;
         end
         if (count_ff != '0) begin
            entry_in.data  = backlog_ff[0];
            entry_in.ready = 1'b1;
            for (int j = 0; j < BACKLOG_DEPTH - 1; j++) backlog_in[j] = backlog_ff[j+1];
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff   <= '0;
         backlog_ff <= '0;
         count_ff   <= '0;
      end else begin
         entry_ff   <= entry_in;
         backlog_ff <= backlog_in;
         count_ff   <= count_in;
      end
   end

   assign entry   = entry_ff;
   assign backlog = backlog_ff;
   assign count   = count_ff;

endmodule

>>> tb/erq_checker.sv
// Checker for the event registration queue: predicts results and compares them.
`timescale 1ns / 1ps
module erq_checker import erq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_ident,
   input  logic        req_filter_kind,
   input  logic [1:0]  req_entry_kind,
   input  logic [63:0] req_user_word,
   input  logic [63:0] req_delay_ns,
   input  logic [6:0]  req_max_count,
   input  logic [63:0] req_now_time,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_ev_ident,
   input  logic        rsp_ev_filter,
   input  logic [5:0]  rsp_ev_flags,
   input  logic [63:0] rsp_ev_data,
   input  logic [63:0] rsp_ev_udata,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending,
   output int          events_seen,
   output int          results_seen
);
   localparam int NSLOT = erq_pkg::SLOTS_DEF;
   localparam int NBL   = erq_pkg::BACKLOG_DEPTH_DEF;

   typedef struct {
      bit [2:0]  status;
      bit [31:0] ident;
      bit        filter;
      bit [5:0]  flags;
      bit [63:0] data;
      bit [63:0] udata;
      bit        last;
   } result_type;

   result_type expected_q[$];
   bit        e_valid [NSLOT];
   bit [31:0] e_ident [NSLOT];
   bit        e_filter[NSLOT];
   bit [1:0]  e_kind  [NSLOT];
   bit        e_ready [NSLOT];
   bit [63:0] e_data  [NSLOT];
   bit [63:0] e_udata [NSLOT];
   bit [63:0] e_dline [NSLOT];
   int        e_rank  [NSLOT];
   bit [63:0] e_bl    [NSLOT][NBL];
   int        e_blcnt [NSLOT];
   bit        closed;
   int        live;

   task automatic push_plain(input bit [2:0] st);
      result_type r;
      r = '{default: 0};
      r.status = st;
      r.last = 1;
      expected_q.insert(expected_q.size(), r);
   endtask

   task automatic push_event(input int s);
      result_type r;
      r = '{default: 0};
      r.status = erq_pkg::ST_OK;
      r.ident = e_ident[s];
      r.filter = e_filter[s];
      case (e_kind[s])
         erq_pkg::KIND_LEVEL:   r.flags = erq_pkg::FL_ADD;
         erq_pkg::KIND_ONESHOT: r.flags = erq_pkg::FL_ADD | erq_pkg::FL_ONESHOT;
         default:               r.flags = erq_pkg::FL_ADD | erq_pkg::FL_CLEAR;
      endcase
      r.data = e_data[s];
      r.udata = e_udata[s];
      expected_q.insert(expected_q.size(), r);
   endtask

   task automatic drop_entry(input int s);
      int rk;
      rk = e_rank[s];
      e_valid[s] = 0;
      e_ready[s] = 0;
      e_blcnt[s] = 0;
      for (int i = 0; i < NSLOT; i++)
         if (e_valid[i] && e_rank[i] > rk) e_rank[i]--;
      if (live > 0) live--;
   endtask

   task automatic run_poll(input bit [63:0] now, input int num);
      int p, n, s;
      bit gone;
      p = 0;
      n = 0;
      for (int i = 0; i < NSLOT; i++)
         if (e_valid[i] && !e_ready[i] && e_dline[i] != 0 && e_dline[i] <= now)
            e_ready[i] = 1;
      while (p < live && n < num) begin
         s = -1;
         for (int i = 0; i < NSLOT; i++)
            if (s < 0 && e_valid[i] && e_rank[i] == p) s = i;
         if (s < 0) break;
         gone = 0;
         while (e_ready[s]) begin
            push_event(s);
            n++;
            if (e_kind[s] == erq_pkg::KIND_ONESHOT) begin
               drop_entry(s);
               gone = 1;
               break;
            end
            if (e_kind[s] != erq_pkg::KIND_LEVEL) begin
               e_ready[s] = 0;
               e_data[s] = 0;
            end
            if (e_blcnt[s] > 0) begin
               e_data[s] = e_bl[s][0];
               for (int j = 0; j < NBL - 1; j++) e_bl[s][j] = e_bl[s][j+1];
               e_blcnt[s]--;
               e_ready[s] = 1;
            end
            if (e_kind[s] == erq_pkg::KIND_LEVEL || n >= num) break;
         end
         if (!gone) p++;
      end
      if (n == 0) push_plain(erq_pkg::ST_NONE);
      else expected_q[$].last = 1;
   endtask

   task automatic predict_request();
      int s, k, num;
      bit [64:0] sum;
      bit [63:0] dl;
      s = -1;
      if (req_type > erq_pkg::REQ_CLOSE) return;
      if (req_type == erq_pkg::REQ_CLOSE) begin
         if (closed) begin
            push_plain(erq_pkg::ST_CLOSED);
            return;
         end
         closed = 1;
         for (int i = 0; i < NSLOT; i++) begin
            e_valid[i] = 0;
            e_ready[i] = 0;
            e_blcnt[i] = 0;
         end
         live = 0;
         push_plain(erq_pkg::ST_OK);
         return;
      end
      if (closed) begin
         push_plain(erq_pkg::ST_CLOSED);
         return;
      end
      for (int i = 0; i < NSLOT; i++)
         if (s < 0 && e_valid[i] && e_ident[i] == req_ident && e_filter[i] == req_filter_kind)
            s = i;
      case (req_type)
         erq_pkg::REQ_ADD: begin
            dl = 0;
            if (req_entry_kind == erq_pkg::KIND_ONESHOT) begin
               sum = {1'b0, req_now_time} + {1'b0, req_delay_ns};
               dl = sum[64] ? '1 : sum[63:0];
               if (dl == 0) dl = 1;
            end
            if (s >= 0) begin
               e_dline[s] = dl;
               e_udata[s] = req_user_word;
               push_plain(erq_pkg::ST_OK);
            end else if (live >= NSLOT) begin
               push_plain(erq_pkg::ST_FULL);
            end else begin
               k = 0;
               while (e_valid[k]) k++;
               e_valid[k] = 1;
               e_ident[k] = req_ident;
               e_filter[k] = req_filter_kind;
               e_kind[k] = req_entry_kind;
               e_ready[k] = 0;
               e_data[k] = 0;
               e_udata[k] = req_user_word;
               e_dline[k] = dl;
               e_rank[k] = live;
               e_blcnt[k] = 0;
               live++;
               push_plain(erq_pkg::ST_OK);
            end
         end
         erq_pkg::REQ_POLL: begin
            num = req_max_count;
            if (num < 1) num = 1;
            if (num > 64) num = 64;
            run_poll(req_now_time, num);
         end
         default: begin
            if (s < 0) push_plain(erq_pkg::ST_NOTFOUND);
            else if (req_type == erq_pkg::REQ_DELETE) begin
               drop_entry(s);
               push_plain(erq_pkg::ST_OK);
            end else if (e_kind[s] == erq_pkg::KIND_LEVEL || e_kind[s] == erq_pkg::KIND_EDGE) begin
               e_ready[s] = 1;
               e_data[s] = req_user_word;
               e_udata[s] = req_user_word;
               push_plain(erq_pkg::ST_OK);
            end else if (e_kind[s] == erq_pkg::KIND_ONESHOT) begin
               e_ready[s] = 1;
               push_plain(erq_pkg::ST_OK);
            end else if (!e_ready[s]) begin
               e_data[s] = req_user_word;
               e_ready[s] = 1;
               push_plain(erq_pkg::ST_OK);
            end else if (e_blcnt[s] < NBL) begin
               e_bl[s][e_blcnt[s]] = req_user_word;
               e_blcnt[s]++;
               push_plain(erq_pkg::ST_OK);
            end else push_plain(erq_pkg::ST_OVERFLOW);
         end
      endcase
   endtask

   task automatic check_result();
      result_type x;
      results_seen++;
      if (rsp_status == erq_pkg::ST_OK && rsp_ev_flags != 0) events_seen++;
      if (expected_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) $display("unexpected result status %0d", rsp_status);
         return;
      end
      x = expected_q[0];
      expected_q.delete(0);
      if (rsp_status !== x.status || rsp_ev_ident !== x.ident || rsp_ev_filter !== x.filter ||
          rsp_ev_flags !== x.flags || rsp_ev_data !== x.data || rsp_ev_udata !== x.udata ||
          rsp_last !== x.last) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch: expected st=%0d id=%h f=%0d fl=%h d=%h u=%h l=%0d, got st=%0d id=%h f=%0d fl=%h d=%h u=%h l=%0d",
                     x.status, x.ident, x.filter, x.flags, x.data, x.udata, x.last,
                     rsp_status, rsp_ev_ident, rsp_ev_filter, rsp_ev_flags, rsp_ev_data,
                     rsp_ev_udata, rsp_last);
      end
   endtask

   initial begin
      fail_count = 0;
      events_seen = 0;
      results_seen = 0;
      closed = 0;
      live = 0;
      foreach (e_valid[i]) begin
         e_valid[i] = 0;
         e_ready[i] = 0;
         e_blcnt[i] = 0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) predict_request();
      end
      pending = expected_q.size();
   end
endmodule

>>> tb/event_registration_queue_tb.sv
// Testbench top for the event registration queue: stimulus, idling and verdict.
`timescale 1ns / 1ps
module event_registration_queue_tb import erq_pkg::*;;
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  r_type;
   logic [31:0] r_ident;
   logic        r_filter;
   logic [1:0]  r_kind;
   logic [63:0] r_word;
   logic [63:0] r_delay;
   logic [6:0]  r_count;
   logic [63:0] r_now;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_ev_ident;
   logic        rsp_ev_filter;
   logic [5:0]  rsp_ev_flags;
   logic [63:0] rsp_ev_data;
   logic [63:0] rsp_ev_udata;
   logic        rsp_last;
   int          fail_count, pending, events_seen, results_seen;
   int          send_idle, recv_idle, requests_sent, quiet_cycles;
   bit [63:0]   now_ns;
   bit [31:0]   id_pool[20];

   event_registration_queue uut (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_type(r_type), .req_ident(r_ident), .req_filter_kind(r_filter),
      .req_entry_kind(r_kind), .req_user_word(r_word), .req_delay_ns(r_delay),
      .req_max_count(r_count), .req_now_time(r_now), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_status(rsp_status), .rsp_ev_ident(rsp_ev_ident),
      .rsp_ev_filter(rsp_ev_filter), .rsp_ev_flags(rsp_ev_flags), .rsp_ev_data(rsp_ev_data),
      .rsp_ev_udata(rsp_ev_udata), .rsp_last(rsp_last)
   );

   erq_checker u_checker (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_type(r_type), .req_ident(r_ident), .req_filter_kind(r_filter),
      .req_entry_kind(r_kind), .req_user_word(r_word), .req_delay_ns(r_delay),
      .req_max_count(r_count), .req_now_time(r_now), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_status(rsp_status), .rsp_ev_ident(rsp_ev_ident),
      .rsp_ev_filter(rsp_ev_filter), .rsp_ev_flags(rsp_ev_flags), .rsp_ev_data(rsp_ev_data),
      .rsp_ev_udata(rsp_ev_udata), .rsp_last(rsp_last), .fail_count(fail_count),
      .pending(pending), .events_seen(events_seen), .results_seen(results_seen)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock)
      rsp_stall <= !reset && ($urandom_range(0, 99) < recv_idle);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send(input logic [2:0] t, input logic [31:0] id, input logic flt,
                       input logic [1:0] k, input logic [63:0] w, input logic [63:0] d,
                       input logic [6:0] c, input logic [63:0] n);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      r_type <= t;
      r_ident <= id;
      r_filter <= flt;
      r_kind <= k;
      r_word <= w;
      r_delay <= d;
      r_count <= c;
      r_now <= n;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_request();
      int r;
      logic [2:0] t;
      logic [63:0] d, n;
      r = $urandom_range(0, 99);
      if (r < 5) t = 3'($urandom_range(5, 7));
      else if (r < 33) t = erq_pkg::REQ_ADD;
      else if (r < 63) t = erq_pkg::REQ_TRIGGER;
      else if (r < 75) t = erq_pkg::REQ_DELETE;
      else t = erq_pkg::REQ_POLL;
      d = ($urandom_range(0, 9) < 7) ? 64'($urandom_range(0, 300)) : {$urandom, $urandom};
      now_ns += $urandom_range(0, 100);
      n = ($urandom_range(0, 99) < 3) ? {$urandom, $urandom} : now_ns;
      send(t, id_pool[$urandom_range(0, 19)], 1'($urandom), 2'($urandom),
           {$urandom, $urandom}, d,
           ($urandom_range(0, 9) < 8) ? 7'($urandom_range(1, 8)) : 7'($urandom_range(0, 127)),
           n);
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      rsp_stall = 0;
      r_type = 0; r_ident = 0; r_filter = 0; r_kind = 0;
      r_word = 0; r_delay = 0; r_count = 1; r_now = 0;
      send_idle = 29;
      recv_idle = 48;
      requests_sent = 0;
      quiet_cycles = 0;
      now_ns = 1000;
      id_pool[0] = 0;
      id_pool[1] = '1;
      for (int i = 2; i < 20; i++) id_pool[i] = $urandom;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send(erq_pkg::REQ_ADD, 0, 0, erq_pkg::KIND_LEVEL, '1, 0, 1, 0);
      send(erq_pkg::REQ_ADD, '1, 1, erq_pkg::KIND_EDGE, 64'h5a5a, '1, 1, '1);
      send(erq_pkg::REQ_ADD, 1, 1, erq_pkg::KIND_ONESHOT, 7, '1, 1, 500);
      send(erq_pkg::REQ_ADD, 2, 1, erq_pkg::KIND_ONESHOT, 8, 0, 1, 0);
      send(erq_pkg::REQ_ADD, 3, 0, erq_pkg::KIND_QUEUED, 9, 0, 1, 0);
      for (int i = 0; i < 11; i++)
         send(erq_pkg::REQ_ADD, 32'(10 + i), 1'(i % 2), 2'(i % 4), {$urandom, $urandom},
              5, 1, 100);
      send(erq_pkg::REQ_ADD, 99, 0, erq_pkg::KIND_LEVEL, 1, 0, 1, 0);
      for (int i = 0; i < 6; i++)
         send(erq_pkg::REQ_TRIGGER, 3, 0, 0, 64'(100 + i), 0, 1, 0);
      send(erq_pkg::REQ_TRIGGER, 0, 0, 0, 64'h1234, 0, 1, 0);
      send(erq_pkg::REQ_TRIGGER, 2, 1, 0, '1, 0, 1, 0);
      send(erq_pkg::REQ_TRIGGER, 77, 0, 0, 0, 0, 1, 0);
      send(erq_pkg::REQ_ADD, 0, 0, erq_pkg::KIND_EDGE, 64'hfeed, 0, 1, 0);
      send(erq_pkg::REQ_POLL, 0, 0, 0, 0, 0, 0, 200);
      send(erq_pkg::REQ_POLL, 0, 0, 0, 0, 0, 127, '1);
      send(erq_pkg::REQ_DELETE, '1, 1, 0, 0, 0, 1, 0);
      send(erq_pkg::REQ_DELETE, 55, 1, 0, 0, 0, 1, 0);
      send(3'd5, 0, 0, 0, 0, 0, 1, 0);
      send(erq_pkg::REQ_POLL, 0, 0, 0, 0, 0, 64, '1);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 29 : (ph == 1) ? 48 : 0;
         recv_idle = (ph == 0) ? 48 : (ph == 1) ? 29 : 0;
         for (int i = 0; i < 90; i++) random_request();
         drain();
      end

      send(erq_pkg::REQ_CLOSE, 0, 0, 0, 0, 0, 1, 0);
      send(erq_pkg::REQ_CLOSE, 0, 0, 0, 0, 0, 1, 0);
      send(erq_pkg::REQ_ADD, 4, 0, 0, 0, 0, 1, 0);
      send(erq_pkg::REQ_TRIGGER, 4, 0, 0, 0, 0, 1, 0);
      send(erq_pkg::REQ_DELETE, 4, 0, 0, 0, 0, 1, 0);
      send(erq_pkg::REQ_POLL, 0, 0, 0, 0, 0, 1, 0);
      drain();
      repeat (50) @(posedge clock);

      $display("Sent %0d requests covering add, trigger, delete, poll, close and unknown codes;",
               requests_sent);
      $display("checked %0d results, %0d of them reported events.", results_seen, events_seen);
      if (fail_count == 0 && pending == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
